### src/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, constants and the bucket hash of the profile sample
// aggregator.
// ----------------------------------------------------------------------------
package psa_pkg;

  // Field widths of the sample, eviction record and configuration port
  localparam int PC_W       = 32;
  localparam int PID_W      = 15;
  localparam int CTR_W      = 1;
  localparam int CNT_OUT_W  = 15;
  localparam int SLOT_W     = 14;
  localparam int HB_W       = 13;
  localparam int BS_W       = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Default sizes
  localparam int WAYS_DEF        = 4;
  localparam int MAX_BUCKETS_DEF = 4096;
  localparam int MAX_BUFFER_DEF  = 16384;
  localparam int COUNT_BITS_DEF  = 15;

  // Register reset values
  localparam logic [HB_W-1:0] HB_RST = HB_W'(2048);
  localparam logic [BS_W-1:0] BS_RST = BS_W'(2048);

  // Hash constants
  localparam logic [31:0] HASH_PC_MASK  = 32'h000f_f000;
  localparam logic [31:0] HASH_PID_MASK = 32'h0000_00ff;
  localparam int          HASH_PC_SHR   = 3;
  localparam int          HASH_PC_SHL   = 9;
  localparam int          HASH_CTR_SHL  = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_BUCKETS = 2'd0,
    REG_BUFFER_SLOTS = 2'd1
  } cfg_reg_e;

  // Control states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } psa_state_e;

  // One evicted record as it leaves the table
  typedef struct packed {
    logic [PC_W-1:0]      pc;
    logic [PID_W-1:0]     pid;
    logic [CTR_W-1:0]     ctr;
    logic [CNT_OUT_W-1:0] count;
  } evict_rec_t;

  // Decision of one bucket update
  typedef struct packed {
    logic       evict;
    logic       adv_victim;
    evict_rec_t rec;
  } psa_dec_t;

  // Full 32-bit bucket hash
  function automatic logic [31:0] psa_hash(logic [PC_W-1:0] pc, logic [PID_W-1:0] pid,
                                           logic [CTR_W-1:0] ctr);
    logic [31:0] h;
    h = ((pc & HASH_PC_MASK) >> HASH_PC_SHR) ^ pc ^ (32'(pid) & HASH_PID_MASK)
        ^ (pc << HASH_PC_SHL) ^ (32'(ctr) << HASH_CTR_SHL);
    return h;
  endfunction

endpackage

### src/psa_ifs.sv
// ----------------------------------------------------------------------------
// psa_ifs
// Valid/ready channels of the aggregator: samples in, evicted records out,
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface psa_sample_if;
  import psa_pkg::*;
  logic             valid;
  logic             ready;
  logic [PC_W-1:0]  program_counter;
  logic [PID_W-1:0] process_id;
  logic [CTR_W-1:0] counter_select;

  modport source (output valid, program_counter, process_id, counter_select,
                  input ready);
  modport sink   (input valid, program_counter, process_id, counter_select,
                  output ready);
endinterface

interface psa_evict_if;
  import psa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PC_W-1:0]      evicted_pc;
  logic [PID_W-1:0]     evicted_pid;
  logic [CTR_W-1:0]     evicted_counter;
  logic [CNT_OUT_W-1:0] evicted_count;
  logic [SLOT_W-1:0]    buffer_slot;
  logic                 buffer_wrapped;

  modport source (output valid, evicted_pc, evicted_pid, evicted_counter, evicted_count,
                  buffer_slot, buffer_wrapped, input ready);
  modport sink   (input valid, evicted_pc, evicted_pid, evicted_counter, evicted_count,
                  buffer_slot, buffer_wrapped, output ready);
endinterface

interface psa_cfg_if;
  import psa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/psa_table_mem.sv
// ----------------------------------------------------------------------------
// psa_table_mem
// Bucket memory: one row holds all lines of a bucket. Registered synchronous
// read, one write port, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module psa_table_mem #(
  parameter int DEPTH = 4096,
  parameter int ROW_W = 252,
  parameter int ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [ROW_W-1:0]  rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [ROW_W-1:0]  wr_data_i,
  output logic              busy_o
);

  logic [ROW_W-1:0]  mem [DEPTH];
  logic [ROW_W-1:0]  rd_q;
  logic              clr_q, clr_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [ROW_W-1:0]  wd;

  // Sweep every row once after reset
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Select the write source
  assign we = clr_q | wr_en_i;
  assign wa = clr_q ? clr_addr_q : wr_addr_i;
  assign wd = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = clr_q;

endmodule

### src/psa_way_select.sv
// ----------------------------------------------------------------------------
// psa_way_select
// Bucket update logic: compares the sample key against every line, picks
// the first matching or empty line, else the victim, and builds the new row
// and the eviction record.
// ----------------------------------------------------------------------------
module psa_way_select #(
  parameter int WAYS = 4,
  parameter int COUNT_BITS = 15,
  parameter int WAY_W = 2,
  parameter int ROW_W = 252
) (
  input  logic [ROW_W-1:0]          row_i,
  input  logic [psa_pkg::PC_W-1:0]  pc_i,
  input  logic [psa_pkg::PID_W-1:0] pid_i,
  input  logic [psa_pkg::CTR_W-1:0] ctr_i,
  input  logic [WAY_W-1:0]          victim_i,
  output logic [ROW_W-1:0]          row_o,
  output psa_pkg::psa_dec_t         dec_o
);
  import psa_pkg::*;

  localparam int LINE_W  = PC_W + PID_W + CTR_W + COUNT_BITS;
  localparam int CTR_LSB = COUNT_BITS;
  localparam int PID_LSB = COUNT_BITS + CTR_W;
  localparam int PC_LSB  = COUNT_BITS + CTR_W + PID_W;
  localparam logic [COUNT_BITS-1:0] CNT_FULL = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

  logic [LINE_W-1:0]     lines   [WAYS];
  logic [LINE_W-1:0]     lines_n [WAYS];
  logic [WAYS-1:0]       hit, empty;
  logic                  found;
  logic [WAY_W-1:0]      sel, way;
  logic [LINE_W-1:0]     cur, upd;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  cur_hit;
  logic [31:0]           cnt32;
  logic [LINE_W-1:0]     fresh;

  // Split the row and match each line
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      lines[i] = row_i[i*LINE_W +: LINE_W];
      empty[i] = (lines[i][COUNT_BITS-1:0] == '0);
      hit[i]   = !empty[i] && (lines[i][PC_LSB +: PC_W] == pc_i)
                 && (lines[i][PID_LSB +: PID_W] == pid_i)
                 && (lines[i][CTR_LSB +: CTR_W] == ctr_i);
    end
  end

  // First line that matches or is empty
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && (hit[i] || empty[i])) begin
        found = 1'b1;
        sel   = WAY_W'(i);
      end
    end
  end

  assign way     = found ? sel : victim_i;
  assign cur     = lines[way];
  assign cur_cnt = cur[COUNT_BITS-1:0];
  assign cur_hit = found && hit[sel];
  assign fresh   = {pc_i, pid_i, ctr_i, CNT_ONE};
  assign cnt32   = 32'(cur_cnt);

  // Bump, restart or replace the chosen line
  always_comb begin
    upd         = fresh;
    dec_o.evict = 1'b1;
    if (cur_hit && (cur_cnt != CNT_FULL)) begin
      upd         = {cur[LINE_W-1:COUNT_BITS], cur_cnt + CNT_ONE};
      dec_o.evict = 1'b0;
    end else if (found && !cur_hit) begin
      dec_o.evict = 1'b0;
    end
    dec_o.adv_victim = !found;
    dec_o.rec.pc     = cur[PC_LSB +: PC_W];
    dec_o.rec.pid    = cur[PID_LSB +: PID_W];
    dec_o.rec.ctr    = cur[CTR_LSB +: CTR_W];
    dec_o.rec.count  = cnt32[CNT_OUT_W-1:0];
  end

  // Rebuild the row
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      lines_n[i]                  = (WAY_W'(i) == way) ? upd : lines[i];
      row_o[i*LINE_W +: LINE_W]   = lines_n[i];
    end
  end

endmodule

### src/psa_evict_buf.sv
// ----------------------------------------------------------------------------
// psa_evict_buf
// Eviction buffer position and output register: assigns each evicted item
// its slot and wrap flag and holds it until the sink takes it.
// ----------------------------------------------------------------------------
module psa_evict_buf #(
  parameter int MAX_BUFFER = 16384,
  parameter int POS_W = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [psa_pkg::BS_W-1:0] buffer_slots_i,
  input  logic                     push_i,
  input  psa_pkg::evict_rec_t      rec_i,
  output logic                     free_o,
  psa_evict_if.source              evict_o
);
  import psa_pkg::*;

  logic             valid_q, valid_d;
  evict_rec_t       rec_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [SLOT_W-1:0] slot_q;
  logic             wrap_q, wrap_d;
  logic [31:0]      len32, nxt32, pos32;

  assign free_o = !valid_q || evict_o.ready;

  // Clamp the length and advance the position
  assign len32 = (32'(buffer_slots_i) > 32'(MAX_BUFFER)) ? 32'(MAX_BUFFER)
                                                         : 32'(buffer_slots_i);
  assign pos32 = 32'(pos_q);
  assign nxt32 = pos32 + 32'd1;

  always_comb begin
    pos_d   = pos_q;
    wrap_d  = 1'b0;
    valid_d = valid_q && !evict_o.ready;
    if (push_i) begin
      valid_d = 1'b1;
      if (nxt32 >= len32) begin
        pos_d  = '0;
        wrap_d = 1'b1;
      end else begin
        pos_d = nxt32[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  // Load the output item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rec_q  <= rec_i;
      slot_q <= pos32[SLOT_W-1:0];
      wrap_q <= wrap_d;
    end
  end

  assign evict_o.valid           = valid_q;
  assign evict_o.evicted_pc      = rec_q.pc;
  assign evict_o.evicted_pid     = rec_q.pid;
  assign evict_o.evicted_counter = rec_q.ctr;
  assign evict_o.evicted_count   = rec_q.count;
  assign evict_o.buffer_slot     = slot_q;
  assign evict_o.buffer_wrapped  = wrap_q;

endmodule

### src/profile_sample_aggregator_unit.sv
// ----------------------------------------------------------------------------
// profile_sample_aggregator_unit
// Aggregates profiling samples in a set-associative bucket table held in a
// synchronous memory and emits evicted records with their buffer slot.
// ----------------------------------------------------------------------------
// Output: an evicted item is registered as its bucket is written back.
// Flow: a new sample is taken only once the last one is written back, set by
//   the bucket read and the write-back through the single table memory; the
//   write-back is held while an eviction waits for the output register to drain.
// Reset: registers return to defaults, then a clearing pass writes all
//   MAX_BUCKETS rows, one per cycle, with no sample taken; configuration
//   writes are taken throughout.
module profile_sample_aggregator_unit #(
  parameter int WAYS        = psa_pkg::WAYS_DEF,
  parameter int MAX_BUCKETS = psa_pkg::MAX_BUCKETS_DEF,
  parameter int MAX_BUFFER  = psa_pkg::MAX_BUFFER_DEF,
  parameter int COUNT_BITS  = psa_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psa_sample_if.sink sample_i,
  psa_evict_if.source evict_o,
  psa_cfg_if.sink    cfg_i
);
  import psa_pkg::*;

  localparam int LINE_W = PC_W + PID_W + CTR_W + COUNT_BITS;
  localparam int ROW_W  = WAYS * LINE_W;
  localparam int BKT_W  = $clog2(MAX_BUCKETS);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int POS_W  = $clog2(MAX_BUFFER);

  psa_state_e       state_q, state_d;
  logic [HB_W-1:0]  hb_q;
  logic [BS_W-1:0]  bs_q;
  logic [WAY_W-1:0] victim_q, victim_d;
  logic [PC_W-1:0]  pc_q;
  logic [PID_W-1:0] pid_q;
  logic [CTR_W-1:0] ctr_q;
  logic [BKT_W-1:0] bkt_q;

  logic             accept, done, busy, out_free;
  logic [31:0]      hash, bkt32;
  logic [HB_W-1:0]  hb_mask;
  logic [BKT_W-1:0] bkt;
  logic [ROW_W-1:0] row_rd, row_wr;
  psa_dec_t         dec;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q <= HB_RST;
      bs_q <= BS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_HASH_BUCKETS: hb_q <= cfg_i.data[HB_W-1:0];
        REG_BUFFER_SLOTS: bs_q <= cfg_i.data[BS_W-1:0];
        default: ;
      endcase
    end
  end

  // Hash the incoming sample into a bucket
  assign hash    = psa_hash(sample_i.program_counter, sample_i.process_id,
                            sample_i.counter_select);
  assign hb_mask = hb_q - HB_W'(1);
  assign bkt32   = hash & 32'(hb_mask) & 32'(MAX_BUCKETS - 1);
  assign bkt     = bkt32[BKT_W-1:0];

  assign sample_i.ready = (state_q == ST_IDLE) && !busy;
  assign accept         = sample_i.valid && sample_i.ready;

  // Control: take a sample, then write the bucket back
  always_comb begin
    state_d  = state_q;
    done     = 1'b0;
    victim_d = victim_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        done = !dec.evict || out_free;
        if (done) begin
          state_d = ST_IDLE;
          if (dec.adv_victim) begin
            victim_d = (victim_q == WAY_W'(WAYS - 1)) ? '0 : victim_q + WAY_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      victim_q <= '0;
    end else begin
      state_q  <= state_d;
      victim_q <= victim_d;
    end
  end

  // Hold the sample key and bucket for the write-back
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pc_q  <= sample_i.program_counter;
      pid_q <= sample_i.process_id;
      ctr_q <= sample_i.counter_select;
      bkt_q <= bkt;
    end
  end

  psa_table_mem #(
    .DEPTH  (MAX_BUCKETS),
    .ROW_W  (ROW_W),
    .ADDR_W (BKT_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (bkt),
    .rd_data_o (row_rd),
    .wr_en_i   (done),
    .wr_addr_i (bkt_q),
    .wr_data_i (row_wr),
    .busy_o    (busy)
  );

  psa_way_select #(
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS),
    .WAY_W      (WAY_W),
    .ROW_W      (ROW_W)
  ) u_sel (
    .row_i    (row_rd),
    .pc_i     (pc_q),
    .pid_i    (pid_q),
    .ctr_i    (ctr_q),
    .victim_i (victim_q),
    .row_o    (row_wr),
    .dec_o    (dec)
  );

  psa_evict_buf #(
    .MAX_BUFFER (MAX_BUFFER),
    .POS_W      (POS_W)
  ) u_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .buffer_slots_i (bs_q),
    .push_i         (done && dec.evict),
    .rec_i          (dec.rec),
    .free_o         (out_free),
    .evict_o        (evict_o)
  );

endmodule
